### rtl/path_command_absolutizer_defines.svh
`ifndef PATH_COMMAND_ABSOLUTIZER_DEFINES_SVH
`define PATH_COMMAND_ABSOLUTIZER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define PCA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pca check failed");

// Next-cycle implication, clocked on clk, off during rst.
`define PCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pca check failed");

`endif

### rtl/pca_pkg.sv
`timescale 1ns / 1ps

package pca_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FIFO_DEPTH_DEF  = 2;

  localparam int FIELD_W   = 32;
  localparam int S_TDATA_W = 232;
  localparam int S_TUSER_W = 6;
  localparam int M_TDATA_W = 232;
  localparam int M_TUSER_W = 4;
  localparam int PROD_W    = 60;

  // round(pi/180 * 2^32)
  localparam logic signed [27:0] DEG2RAD_Q32 = 28'sd74961321;

  localparam logic [4:0] CMD_MOVE        = 5'd0;
  localparam logic [4:0] CMD_MOVE_REL    = 5'd1;
  localparam logic [4:0] CMD_LINE        = 5'd2;
  localparam logic [4:0] CMD_LINE_REL    = 5'd3;
  localparam logic [4:0] CMD_HLINE       = 5'd4;
  localparam logic [4:0] CMD_HLINE_REL   = 5'd5;
  localparam logic [4:0] CMD_VLINE       = 5'd6;
  localparam logic [4:0] CMD_VLINE_REL   = 5'd7;
  localparam logic [4:0] CMD_CUBIC       = 5'd8;
  localparam logic [4:0] CMD_CUBIC_REL   = 5'd9;
  localparam logic [4:0] CMD_SMOOTH      = 5'd10;
  localparam logic [4:0] CMD_SMOOTH_REL  = 5'd11;
  localparam logic [4:0] CMD_QUAD        = 5'd12;
  localparam logic [4:0] CMD_QUAD_REL    = 5'd13;
  localparam logic [4:0] CMD_QSMOOTH     = 5'd14;
  localparam logic [4:0] CMD_QSMOOTH_REL = 5'd15;
  localparam logic [4:0] CMD_ARC         = 5'd16;
  localparam logic [4:0] CMD_ARC_REL     = 5'd17;
  localparam logic [4:0] CMD_CLOSE       = 5'd18;

  typedef enum logic [3:0] {
    PRIM_NONE         = 4'd0,
    PRIM_MOVE         = 4'd1,
    PRIM_LINE         = 4'd2,
    PRIM_CUBIC        = 4'd3,
    PRIM_SMOOTH_CUBIC = 4'd4,
    PRIM_QUAD         = 4'd5,
    PRIM_SMOOTH_QUAD  = 4'd6,
    PRIM_ARC          = 4'd7,
    PRIM_CLOSE        = 4'd8
  } prim_t;

  typedef struct packed {
    logic  path_start;
    logic  known;
    logic  close;
    logic  rel;
    logic  keep_x;
    logic  keep_y;
    logic  draws;
    logic  offs_ctrl;
    logic  curve;
    prim_t prim;
    logic  large_arc;
    logic  sweep;
  } pca_cmd_t;

endpackage

### rtl/pca_front.sv
`timescale 1ns / 1ps

module pca_front #(
  parameter int COORD_WIDTH = pca_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [pca_pkg::S_TDATA_W-1:0]     s_tdata,
  input  logic [pca_pkg::S_TUSER_W-1:0]     s_tuser,
  output logic                              q_valid,
  input  logic                              q_ready,
  output pca_pkg::pca_cmd_t                 q_cmd,
  output logic [6*COORD_WIDTH-1:0]          q_coords,
  output logic signed [pca_pkg::PROD_W-1:0] q_prod
);

  localparam int W  = COORD_WIDTH;
  localparam int WX = (W > pca_pkg::FIELD_W ? W : pca_pkg::FIELD_W) + 1;
  localparam logic signed [W-1:0]  CMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  CMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [WX-1:0] CMAX_X = {{(WX-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [WX-1:0] CMIN_X = {{(WX-W+1){1'b1}}, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] clampc(input logic signed [31:0] v);
    logic signed [WX-1:0] vx;
    vx = WX'(v);
    if (vx > CMAX_X) begin
      clampc = CMAX;
    end else if (vx < CMIN_X) begin
      clampc = CMIN;
    end else begin
      clampc = vx[W-1:0];
    end
  endfunction

  logic                              fv;
  pca_pkg::pca_cmd_t                 cmd_r;
  logic [6*W-1:0]                    coord_r;
  logic signed [pca_pkg::PROD_W-1:0] prod_r;

  pca_pkg::pca_cmd_t                 cmd_w;
  logic [6*W-1:0]                    coord_w;
  logic signed [pca_pkg::PROD_W-1:0] prod_w;
  logic [4:0]                        kind;
  logic signed [31:0]                deg;
  logic                              acc;
  logic                              keep;

  always_comb begin
    kind = s_tuser[5:1];
    deg  = s_tdata[223:192];
    cmd_w            = '0;
    cmd_w.path_start = s_tuser[0];
    cmd_w.known      = (kind <= pca_pkg::CMD_CLOSE);
    cmd_w.close      = (kind == pca_pkg::CMD_CLOSE);
    cmd_w.rel        = kind[0] && (kind != pca_pkg::CMD_CLOSE);
    cmd_w.keep_y     = (kind == pca_pkg::CMD_HLINE) || (kind == pca_pkg::CMD_HLINE_REL);
    cmd_w.keep_x     = (kind == pca_pkg::CMD_VLINE) || (kind == pca_pkg::CMD_VLINE_REL);
    cmd_w.draws      = (kind >= pca_pkg::CMD_LINE) && (kind < pca_pkg::CMD_CLOSE);
    cmd_w.offs_ctrl  = cmd_w.rel && (kind >= pca_pkg::CMD_LINE) && (kind < pca_pkg::CMD_ARC);
    cmd_w.curve      = (kind >= pca_pkg::CMD_CUBIC);
    cmd_w.large_arc  = s_tdata[224];
    cmd_w.sweep      = s_tdata[225];
    case (kind) inside
      [pca_pkg::CMD_MOVE:pca_pkg::CMD_MOVE_REL]:       cmd_w.prim = pca_pkg::PRIM_MOVE;
      [pca_pkg::CMD_LINE:pca_pkg::CMD_VLINE_REL]:      cmd_w.prim = pca_pkg::PRIM_LINE;
      [pca_pkg::CMD_CUBIC:pca_pkg::CMD_CUBIC_REL]:     cmd_w.prim = pca_pkg::PRIM_CUBIC;
      [pca_pkg::CMD_SMOOTH:pca_pkg::CMD_SMOOTH_REL]:   cmd_w.prim = pca_pkg::PRIM_SMOOTH_CUBIC;
      [pca_pkg::CMD_QUAD:pca_pkg::CMD_QUAD_REL]:       cmd_w.prim = pca_pkg::PRIM_QUAD;
      [pca_pkg::CMD_QSMOOTH:pca_pkg::CMD_QSMOOTH_REL]: cmd_w.prim = pca_pkg::PRIM_SMOOTH_QUAD;
      [pca_pkg::CMD_ARC:pca_pkg::CMD_ARC_REL]:         cmd_w.prim = pca_pkg::PRIM_ARC;
      pca_pkg::CMD_CLOSE:                              cmd_w.prim = pca_pkg::PRIM_CLOSE;
      default:                                         cmd_w.prim = pca_pkg::PRIM_NONE;
    endcase
    for (int i = 0; i < 6; i++) begin
      coord_w[i*W +: W] = clampc(s_tdata[i*32 +: 32]);
    end
    prod_w = pca_pkg::PROD_W'(deg) * pca_pkg::PROD_W'(pca_pkg::DEG2RAD_Q32);
  end

  // unknown kinds without a path start leave no trace
  assign keep     = cmd_w.known || cmd_w.path_start;
  assign s_tready = !fv || q_ready;
  assign acc      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (acc && keep) begin
      fv <= 1'b1;
    end else if (q_ready) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r   <= cmd_w;
      coord_r <= coord_w;
      prod_r  <= prod_w;
    end
  end

  assign q_valid  = fv;
  assign q_cmd    = cmd_r;
  assign q_coords = coord_r;
  assign q_prod   = prod_r;

endmodule

### rtl/pca_fifo.sv
`timescale 1ns / 1ps

module pca_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = pca_pkg::FIFO_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] din,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] dout,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

### rtl/pca_back.sv
`timescale 1ns / 1ps

module pca_back #(
  parameter int COORD_WIDTH = pca_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  pca_pkg::pca_cmd_t                 q_cmd,
  input  logic [6*COORD_WIDTH-1:0]          q_coords,
  input  logic signed [pca_pkg::PROD_W-1:0] q_prod,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pca_pkg::M_TDATA_W-1:0]     m_tdata,
  output logic [pca_pkg::M_TUSER_W-1:0]     m_tuser
);

  localparam int W  = COORD_WIDTH;
  localparam int OX = (W > pca_pkg::FIELD_W) ? W : pca_pkg::FIELD_W;
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [63:0]  RND  = 64'sd2147483648;

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      sadd = s[W] ? CMIN : CMAX;
    end else begin
      sadd = s[W-1:0];
    end
  endfunction

  function automatic logic [31:0] o32(input logic signed [W-1:0] v);
    logic signed [OX-1:0] t;
    t = OX'(v);
    o32 = t[31:0];
  endfunction

  logic                 flat_cap;
  logic signed [W-1:0]  last_x, last_y, start_x, start_y;
  logic                 polygon_open, last_was_curve;

  logic signed [W-1:0]  last_x_next, last_y_next, start_x_next, start_y_next;
  logic                 polygon_open_next, last_was_curve_next;

  logic signed [W-1:0]  blx, bly, bsx, bsy;
  logic                 bpo, blwc;
  logic signed [W-1:0]  ex, ey, ax, ay, bx, by;
  logic signed [W-1:0]  ex_a, ey_a, x, y, x_fin;
  logic signed [W-1:0]  ax_a, ay_a, bx_a, by_a;
  logic signed [63:0]   rq;
  logic [31:0]          rad;
  pca_pkg::prim_t       prim;
  logic                 use_a, use_b, is_arc;
  logic [pca_pkg::M_TDATA_W-1:0] res_data;

  assign q_pop = q_valid && (!m_tvalid || m_tready);

  always_comb begin
    blx  = q_cmd.path_start ? '0 : last_x;
    bly  = q_cmd.path_start ? '0 : last_y;
    bsx  = q_cmd.path_start ? '0 : start_x;
    bsy  = q_cmd.path_start ? '0 : start_y;
    bpo  = q_cmd.path_start ? 1'b0 : polygon_open;
    blwc = q_cmd.path_start ? 1'b0 : last_was_curve;

    ex = q_coords[0*W +: W];
    ey = q_coords[1*W +: W];
    ax = q_coords[2*W +: W];
    ay = q_coords[3*W +: W];
    bx = q_coords[4*W +: W];
    by = q_coords[5*W +: W];

    ex_a = q_cmd.rel ? sadd(ex, blx) : ex;
    ey_a = q_cmd.rel ? sadd(ey, bly) : ey;
    if (q_cmd.close) begin
      x = bsx;
      y = bsy;
    end else begin
      x = q_cmd.keep_x ? blx : ex_a;
      y = q_cmd.keep_y ? bly : ey_a;
    end
    // zero-length segment gets a one-LSB nudge unless the cap is butt
    if (q_cmd.draws && (x == blx) && (y == bly) && !flat_cap) begin
      x_fin = sadd(x, W'(1));
    end else begin
      x_fin = x;
    end

    ax_a = q_cmd.offs_ctrl ? sadd(ax, blx) : ax;
    ay_a = q_cmd.offs_ctrl ? sadd(ay, bly) : ay;
    bx_a = q_cmd.offs_ctrl ? sadd(bx, blx) : bx;
    by_a = q_cmd.offs_ctrl ? sadd(by, bly) : by;

    prim = q_cmd.prim;
    if ((prim == pca_pkg::PRIM_SMOOTH_CUBIC) && !blwc) begin
      prim = pca_pkg::PRIM_QUAD;
    end
    use_a  = (prim == pca_pkg::PRIM_CUBIC) || (prim == pca_pkg::PRIM_SMOOTH_CUBIC) ||
             (prim == pca_pkg::PRIM_QUAD) || (prim == pca_pkg::PRIM_ARC);
    use_b  = (prim == pca_pkg::PRIM_CUBIC);
    is_arc = (prim == pca_pkg::PRIM_ARC);

    // floor((deg * k + 2^31) / 2^32)
    rq  = 64'(q_prod) + RND;
    rad = rq[63:32];

    res_data = {6'd0,
                is_arc && q_cmd.sweep,
                is_arc && q_cmd.large_arc,
                is_arc ? rad : 32'd0,
                use_b ? o32(by_a) : 32'd0,
                use_b ? o32(bx_a) : 32'd0,
                use_a ? o32(ay_a) : 32'd0,
                use_a ? o32(ax_a) : 32'd0,
                o32(y),
                o32(x_fin)};

    last_x_next         = blx;
    last_y_next         = bly;
    start_x_next        = bsx;
    start_y_next        = bsy;
    polygon_open_next   = bpo;
    last_was_curve_next = blwc;
    if (q_cmd.known) begin
      last_x_next = x_fin;
      last_y_next = y;
      if (q_cmd.close) begin
        polygon_open_next = 1'b0;
      end else begin
        last_was_curve_next = q_cmd.curve;
        if (q_cmd.draws) begin
          polygon_open_next = 1'b1;
          if (!bpo) begin
            start_x_next = blx;
            start_y_next = bly;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flat_cap <= 1'b0;
    end else if (cfg_we) begin
      flat_cap <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x         <= '0;
      last_y         <= '0;
      start_x        <= '0;
      start_y        <= '0;
      polygon_open   <= 1'b0;
      last_was_curve <= 1'b0;
    end else if (q_pop) begin
      last_x         <= last_x_next;
      last_y         <= last_y_next;
      start_x        <= start_x_next;
      start_y        <= start_y_next;
      polygon_open   <= polygon_open_next;
      last_was_curve <= last_was_curve_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop && q_cmd.known) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.known) begin
      m_tdata <= res_data;
      m_tuser <= prim;
    end
  end

endmodule

### rtl/path_command_absolutizer.sv
`timescale 1ns / 1ps

// Channel   Dir  tdata (bits)                              tuser (bits)
// s_axis    in   coords, degrees, arc flags (232)          path_start, command_kind (6)
// m_axis    out  abs coords, radians, arc flags (232)      primitive_res (4)
// cfg       in   flat_cap write enable + data (1)          -
//
// One item per cycle sustained while m_axis_tready stays high; the last-point update in the
// back end is a registered loop. An item passes the front register and the queue, then the output register.
// Reset clears the queue, the last/start points, both flags and flat_cap.
// The front stalls only on a full queue, the back only on m_axis_tready.
// Unknown kinds without path_start are dropped at the front.
module path_command_absolutizer #(
  parameter int COORD_WIDTH = pca_pkg::COORD_WIDTH_DEF,
  parameter int FIFO_DEPTH  = pca_pkg::FIFO_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // end_x_in, end_y_in, ctrl_a_x_in, ctrl_a_y_in, ctrl_b_x_in, ctrl_b_y_in,
  // arc_degrees, large_arc_in, sweep_in, zero pad
  input  logic [pca_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // path_start, command_kind
  input  logic [pca_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // end_x, end_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, arc_radians,
  // large_arc, sweep, zero pad
  output logic [pca_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // primitive_res
  output logic [pca_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  localparam int CMD_W   = $bits(pca_pkg::pca_cmd_t);
  localparam int CRD_W   = 6 * COORD_WIDTH;
  localparam int ENTRY_W = CMD_W + CRD_W + pca_pkg::PROD_W;

  logic                              f_valid;
  logic                              f_full;
  pca_pkg::pca_cmd_t                 f_cmd;
  logic [CRD_W-1:0]                  f_coords;
  logic signed [pca_pkg::PROD_W-1:0] f_prod;

  logic                              b_pop;
  logic                              b_empty;
  logic [ENTRY_W-1:0]                b_entry;

  pca_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_axis_tvalid),
    .s_tready(s_axis_tready),
    .s_tdata (s_axis_tdata),
    .s_tuser (s_axis_tuser),
    .q_valid (f_valid),
    .q_ready (!f_full),
    .q_cmd   (f_cmd),
    .q_coords(f_coords),
    .q_prod  (f_prod)
  );

  pca_fifo #(
    .DATA_W(ENTRY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (f_valid),
    .din  ({f_cmd, f_coords, f_prod}),
    .full (f_full),
    .pop  (b_pop),
    .dout (b_entry),
    .empty(b_empty)
  );

  pca_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_valid  (!b_empty),
    .q_pop    (b_pop),
    .q_cmd    (pca_pkg::pca_cmd_t'(b_entry[ENTRY_W-1 -: CMD_W])),
    .q_coords (b_entry[pca_pkg::PROD_W +: CRD_W]),
    .q_prod   (b_entry[pca_pkg::PROD_W-1:0]),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .m_tuser  (m_axis_tuser)
  );

endmodule

### rtl/pca_checker.sv
`timescale 1ns / 1ps
`include "path_command_absolutizer_defines.svh"

module pca_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pca_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [pca_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  `PCA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  `PCA_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // move and line carry no controls, radians or flags
  `PCA_ASSERT_SAME(a_line_clean, m_axis_tvalid && (m_axis_tuser == pca_pkg::PRIM_MOVE || m_axis_tuser == pca_pkg::PRIM_LINE), m_axis_tdata[pca_pkg::M_TDATA_W-1:64] == '0)

  `PCA_ASSERT_SAME(a_arc_only, m_axis_tvalid && (m_axis_tuser != pca_pkg::PRIM_ARC), m_axis_tdata[pca_pkg::M_TDATA_W-1:192] == '0)

endmodule

bind path_command_absolutizer pca_checker u_pca_checker (.*);

### test/path_command_absolutizer_tb.sv
`timescale 1ns / 1ps

module path_command_absolutizer_tb;
  import pca_pkg::*;

  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -CMAX - 1;
  localparam logic [31:0] QMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] QMIN = 32'h8000_0000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [4:0] KIND_OTHER = CMD_CLOSE + 5'd1;
  localparam logic [4:0] KIND_TOP = 5'h1F;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    bit                 path_start;
    logic [4:0]         kind;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] ca_x;
    logic signed [31:0] ca_y;
    logic signed [31:0] cb_x;
    logic signed [31:0] cb_y;
    logic signed [31:0] deg;
    bit                 big_arc;
    bit                 sweep;
  } draw_cmd_t;

  typedef struct {
    prim_t       prim;
    logic [31:0] end_x;
    logic [31:0] end_y;
    logic [31:0] ca_x;
    logic [31:0] ca_y;
    logic [31:0] cb_x;
    logic [31:0] cb_y;
    logic [31:0] rad;
    logic        big_arc;
    logic        sweep;
  } abs_prim_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic                 cfg_wdata = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  // predictor state
  longint cur_x = 0, cur_y = 0, sub_x = 0, sub_y = 0;
  bit     subpath_open = 1'b0, prev_curve = 1'b0, butt_mirror = 1'b0;

  abs_prim_t abs_prim_q[$];
  int        mismatches = 0;
  int        burst_left = 0;
  int        hold_requests = 0;

  path_command_absolutizer u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > CMAX) return CMAX;
    if (s < CMIN) return CMIN;
    return s;
  endfunction

  function automatic bit absolutize(input draw_cmd_t c, output abs_prim_t r);
    longint ex, ey, ax, ay, bx, by, x, y, q;
    bit     rel;
    r.prim = PRIM_NONE;
    r.end_x = '0; r.end_y = '0; r.ca_x = '0; r.ca_y = '0;
    r.cb_x = '0; r.cb_y = '0; r.rad = '0; r.big_arc = 1'b0; r.sweep = 1'b0;
    rel = c.kind[0];
    ex = c.end_x; ey = c.end_y;
    ax = c.ca_x; ay = c.ca_y;
    bx = c.cb_x; by = c.cb_y;
    if (c.path_start) begin
      cur_x = 0; cur_y = 0; sub_x = 0; sub_y = 0;
      subpath_open = 1'b0;
      prev_curve = 1'b0;
    end
    if (c.kind > CMD_CLOSE) return 1'b0;
    if (c.kind == CMD_CLOSE) begin
      x = sub_x;
      y = sub_y;
      subpath_open = 1'b0;
      r.prim = PRIM_CLOSE;
    end else begin
      if (rel) begin
        ex = sat_add(ex, cur_x);
        ey = sat_add(ey, cur_y);
      end
      x = ex;
      y = ey;
      if (c.kind == CMD_HLINE || c.kind == CMD_HLINE_REL) y = cur_y;
      if (c.kind == CMD_VLINE || c.kind == CMD_VLINE_REL) x = cur_x;
      if (c.kind >= CMD_LINE) begin
        if (!subpath_open) begin
          subpath_open = 1'b1;
          sub_x = cur_x;
          sub_y = cur_y;
        end
        if (x == cur_x && y == cur_y && !butt_mirror) x = sat_add(x, 1);
        if (rel && c.kind < CMD_ARC) begin
          ax = sat_add(ax, cur_x);
          ay = sat_add(ay, cur_y);
          bx = sat_add(bx, cur_x);
          by = sat_add(by, cur_y);
        end
      end
      if (c.kind <= CMD_MOVE_REL) begin
        r.prim = PRIM_MOVE;
      end else if (c.kind <= CMD_VLINE_REL) begin
        r.prim = PRIM_LINE;
      end else if (c.kind <= CMD_CUBIC_REL) begin
        r.prim = PRIM_CUBIC;
        r.ca_x = ax[31:0]; r.ca_y = ay[31:0];
        r.cb_x = bx[31:0]; r.cb_y = by[31:0];
      end else if (c.kind <= CMD_SMOOTH_REL) begin
        r.prim = prev_curve ? PRIM_SMOOTH_CUBIC : PRIM_QUAD;
        r.ca_x = ax[31:0]; r.ca_y = ay[31:0];
      end else if (c.kind <= CMD_QUAD_REL) begin
        r.prim = PRIM_QUAD;
        r.ca_x = ax[31:0]; r.ca_y = ay[31:0];
      end else if (c.kind <= CMD_QSMOOTH_REL) begin
        r.prim = PRIM_SMOOTH_QUAD;
      end else begin
        r.prim = PRIM_ARC;
        r.ca_x = ax[31:0]; r.ca_y = ay[31:0];
        // round half up == floor(x + 0.5) in Q32
        q = longint'(c.deg) * longint'(DEG2RAD_Q32) + (longint'(1) <<< 31);
        r.rad = 32'(q >>> 32);
        r.big_arc = c.big_arc;
        r.sweep = c.sweep;
      end
      prev_curve = (c.kind >= CMD_CUBIC);
    end
    r.end_x = x[31:0];
    r.end_y = y[31:0];
    cur_x = x;
    cur_y = y;
    return 1'b1;
  endfunction

  function automatic draw_cmd_t mk(bit ps, logic [4:0] k, logic [31:0] ex = '0,
                                   logic [31:0] ey = '0, logic [31:0] ax = '0,
                                   logic [31:0] ay = '0, logic [31:0] bx = '0,
                                   logic [31:0] by = '0, logic [31:0] deg = '0,
                                   bit la = 1'b0, bit sw = 1'b0);
    draw_cmd_t c;
    c.path_start = ps; c.kind = k;
    c.end_x = ex; c.end_y = ey; c.ca_x = ax; c.ca_y = ay;
    c.cb_x = bx; c.cb_y = by; c.deg = deg;
    c.big_arc = la; c.sweep = sw;
    return c;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return QMAX;
      2: return QMIN;
      3: return int'($urandom_range(0, 16)) - 8;
      4, 5: return int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
      default: return $urandom;
    endcase
  endfunction

  function automatic draw_cmd_t rand_cmd(logic [4:0] k, bit ps);
    draw_cmd_t c;
    c = mk(ps, k, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(0, 1)),
           1'($urandom_range(0, 1)));
    // aim some draws at the current point to hit the zero-length case
    if (!ps && $urandom_range(0, 7) == 0) begin
      c.end_x = k[0] ? 32'sd0 : cur_x[31:0];
      c.end_y = k[0] ? 32'sd0 : cur_y[31:0];
    end
    return c;
  endfunction

  task automatic push_cmd(input draw_cmd_t c);
    abs_prim_t r;
    int        gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      else if ($urandom_range(0, 2) == 0) gap = 0;
      else gap = $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, c.sweep, c.big_arc, c.deg, c.cb_y, c.cb_x, c.ca_y, c.ca_x,
                     c.end_y, c.end_x};
    s_axis_tuser <= {c.kind, c.path_start};
    do @(posedge clk); while (!s_axis_tready);
    if (absolutize(c, r)) abs_prim_q = {abs_prim_q, r};
  endtask

  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    while (abs_prim_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_flat_cap(bit v);
    drain_all();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    butt_mirror = v;
  endtask

  task automatic run_paths(int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 2) begin
        // noise: any kind, stray path starts, unknown kinds
        push_cmd(rand_cmd(5'($urandom_range(0, KIND_TOP)), 1'($urandom_range(0, 1))));
        sent++;
      end else begin
        push_cmd(rand_cmd(5'($urandom_range(CMD_MOVE, CMD_MOVE_REL)), 1'b1));
        sent++;
        len = $urandom_range(1, 12);
        repeat (len) begin
          push_cmd(rand_cmd(5'($urandom_range(CMD_LINE, CMD_CLOSE)), 1'b0));
          sent++;
        end
      end
    end
  endtask

  task automatic test_directed();
    set_flat_cap(1'b0);
    push_cmd(mk(1'b1, CMD_MOVE, ONE, 2 * ONE));
    push_cmd(mk(1'b0, CMD_LINE, 5 * ONE, 2 * ONE));
    push_cmd(mk(1'b0, CMD_LINE_REL, 0, 0));
    push_cmd(mk(1'b0, CMD_HLINE, QMAX, QMIN));
    push_cmd(mk(1'b0, CMD_HLINE_REL, QMAX, 0));
    push_cmd(mk(1'b0, CMD_VLINE_REL, QMAX, QMIN));
    push_cmd(mk(1'b0, CMD_VLINE, 0, QMIN));
    push_cmd(mk(1'b0, CMD_SMOOTH, ONE, ONE, 3 * ONE, 4 * ONE, QMAX, QMIN));
    push_cmd(mk(1'b0, CMD_CUBIC_REL, QMIN, QMIN, QMAX, QMIN, ONE, QMAX));
    push_cmd(mk(1'b0, CMD_SMOOTH_REL, ONE, -ONE, QMAX, QMAX, QMIN, QMIN));
    push_cmd(mk(1'b0, CMD_QUAD, QMAX, QMAX, QMIN, QMAX));
    push_cmd(mk(1'b0, CMD_QUAD_REL, QMIN, 0, QMAX, QMIN));
    push_cmd(mk(1'b0, CMD_QSMOOTH, 7 * ONE, 0, QMAX, QMAX, QMAX, QMAX));
    push_cmd(mk(1'b0, CMD_QSMOOTH_REL, -ONE, ONE));
    push_cmd(mk(1'b0, CMD_ARC, ONE, ONE, QMAX, QMIN, QMAX, QMAX, 180 * ONE, 1'b1, 1'b0));
    push_cmd(mk(1'b0, CMD_ARC_REL, QMAX, QMAX, ONE, ONE, 0, 0, QMIN, 1'b0, 1'b1));
    push_cmd(mk(1'b0, CMD_ARC, 0, 0, QMIN, QMAX, 0, 0, QMAX, 1'b1, 1'b1));
    push_cmd(mk(1'b0, CMD_MOVE_REL, ONE, -ONE));
    push_cmd(mk(1'b0, CMD_CLOSE, QMAX, QMAX));
    push_cmd(mk(1'b0, CMD_CLOSE));
    push_cmd(mk(1'b0, KIND_TOP, QMAX, QMIN));
    push_cmd(mk(1'b1, KIND_OTHER, QMAX, QMAX));
    push_cmd(mk(1'b0, CMD_LINE, 0, 0));
    push_cmd(mk(1'b0, CMD_ARC, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1'b0, 1'b1));
  endtask

  task automatic test_flat_cap();
    set_flat_cap(1'b1);
    push_cmd(mk(1'b0, CMD_LINE_REL, 0, 0));
    push_cmd(mk(1'b0, CMD_HLINE_REL, 0, QMAX));
    push_cmd(mk(1'b0, CMD_CUBIC_REL, 0, 0, ONE, ONE, -ONE, -ONE));
    push_cmd(mk(1'b0, CMD_ARC_REL, 0, 0, ONE, ONE, 0, 0, 90 * ONE, 1'b1, 1'b0));
    run_paths(400);
    set_flat_cap(1'b0);
  endtask

  task automatic test_random_paths();
    run_paths(500);
    set_flat_cap(1'b1);
    run_paths(250);
    set_flat_cap(1'b0);
    run_paths(300);
  endtask

  task automatic test_backpressure();
    drain_all();
    hold_requests++;
    burst_left = 1 << 30;
    run_paths(80);
    burst_left = 0;
    drain_all();
  endtask

  // receiver: random ready/stall runs, plus a long hold-off on request
  int rx_run = 0, hold_left = 0, hold_served = 0;
  bit rx_on = 1'b0;
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_run == 0) begin
        rx_on = !rx_on;
        rx_run = rx_on ? $urandom_range(1, 40) : $urandom_range(1, 6);
      end
      rx_run--;
      m_axis_tready <= rx_on;
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("%t %s: expected %h, got %h", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    abs_prim_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (abs_prim_q.size() == 0) begin
        check_field("unexpected item, primitive", 32'(PRIM_NONE), 32'(m_axis_tuser));
        if (m_axis_tuser == PRIM_NONE) mismatches++;
      end else begin
        want = abs_prim_q.pop_front();
        check_field("primitive", 32'(want.prim), 32'(m_axis_tuser));
        check_field("end_x", want.end_x, m_axis_tdata[31:0]);
        check_field("end_y", want.end_y, m_axis_tdata[63:32]);
        check_field("ctrl_a_x", want.ca_x, m_axis_tdata[95:64]);
        check_field("ctrl_a_y", want.ca_y, m_axis_tdata[127:96]);
        check_field("ctrl_b_x", want.cb_x, m_axis_tdata[159:128]);
        check_field("ctrl_b_y", want.cb_y, m_axis_tdata[191:160]);
        check_field("arc_radians", want.rad, m_axis_tdata[223:192]);
        check_field("large_arc", 32'(want.big_arc), 32'(m_axis_tdata[224]));
        check_field("sweep", 32'(want.sweep), 32'(m_axis_tdata[225]));
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_flat_cap();
    test_random_paths();
    test_backpressure();
    drain_all();
    if (mismatches == 0 && abs_prim_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/pca_pkg.sv
rtl/pca_front.sv
rtl/pca_fifo.sv
rtl/pca_back.sv
rtl/path_command_absolutizer.sv
rtl/pca_checker.sv
test/path_command_absolutizer_tb.sv
